FILE: sv/resp_array_tokenizer_top_assert.svh
// assertion macros for the array tokenizer
// used by resp_array_tokenizer_top.sv, no other dependencies
`ifndef RESP_ARRAY_TOKENIZER_TOP_ASSERT_SVH
`define RESP_ARRAY_TOKENIZER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("resp tokenizer check failed");
`define RT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("resp tokenizer check failed");
`else
`define RT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/resp_tok_pkg.sv
// types and constants for the array tokenizer
// no dependencies
`default_nettype none

package resp_tok_pkg;

  typedef enum logic [9:0] {
    PH_STAR    = 10'b00_0000_0001,
    PH_CNT_DIG = 10'b00_0000_0010,
    PH_CNT_LF  = 10'b00_0000_0100,
    PH_DOLLAR  = 10'b00_0000_1000,
    PH_LEN_DIG = 10'b00_0001_0000,
    PH_LEN_LF  = 10'b00_0010_0000,
    PH_DATA    = 10'b00_0100_0000,
    PH_SKIP    = 10'b00_1000_0000,
    PH_STOP    = 10'b01_0000_0000,
    PH_FAIL    = 10'b10_0000_0000
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // verdicts
  localparam logic [1:0] VERD_ACCEPT  = 2'd0;
  localparam logic [1:0] VERD_DISCARD = 2'd1;
  localparam logic [1:0] VERD_STOPPED = 2'd2;

  // protocol characters
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // result queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] token_byte;
    logic       token_end;
    logic [1:0] verdict;
    logic       run_last;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/resp_array_tokenizer_top.sv
// array tokenizer top level: byte-wise parser for an array of bulk strings
// depends on resp_tok_pkg and resp_array_tokenizer_top_assert.svh
`default_nettype none
`include "resp_array_tokenizer_top_assert.svh"

// Takes one message byte per transfer and parses '*count CR LF' followed by
// elements of the form '$len CR LF', len data bytes and two trailing bytes.
// Data bytes leave as token bytes (token_end on the last), a zero-length
// element leaves as one empty-token result, and the final byte of a message
// produces a verdict (accepted, discard, or stopped early) after which the
// parser is back at its reset state. The whole parse step for a byte is done
// in the cycle the byte is accepted, so one byte can be taken every cycle while
// in_ready is high; results are registered into a 4-entry result queue that
// drains one result per cycle while out_ready is high. A byte that both closes
// a token and ends the message gives two results, so the output side limits
// the rate: in_ready is held low while the queue holds more than two results.
// The length/count accumulate is a shift-and-add by ten with an overflow check
// against LEN_WIDTH bits.
module resp_array_tokenizer_top #(
  parameter int LEN_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input byte channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_message,
  // result channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_token_byte,
  output logic            out_token_end,
  output logic [1:0]      out_verdict,
  output logic            out_run_last
);
  import resp_tok_pkg::*;

  // parser state
  phase_t               phase_r, phase_nxt;
  logic [LEN_WIDTH-1:0] dcount_r, dcount_nxt;   // declared element count
  logic [LEN_WIDTH-1:0] acc_r, acc_nxt;         // decimal accumulator
  logic                 seen_r, seen_nxt;       // a digit in this line
  logic [LEN_WIDTH-1:0] remain_r, remain_nxt;   // data bytes still to come
  logic [1:0]           skip_r, skip_nxt;       // trailing bytes still to skip
  logic [LEN_WIDTH-1:0] tcount_r, tcount_nxt;   // tokens seen so far
  logic                 excess_r, excess_nxt;   // more tokens than declared

  // result queue
  result_t              q_mem [QDEPTH];
  logic [QAW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]       cnt_r, cnt_nxt;

  logic                 in_fire, out_fire;
  logic                 is_digit, line_ok, ovf;
  logic [LEN_WIDTH+3:0] acc_wide, prod;
  logic                 tok_vld;
  result_t              tok_res, verd_res;
  logic [1:0]           verd_code;
  logic [QAW-1:0]       verd_addr;

  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;

  // room for the worst case of two results from one byte
  assign in_ready = (cnt_r <= QCW'(QDEPTH - 2));

  // decimal accumulate: acc * 10 + digit, overflow when the top nibble is set
  assign is_digit = (in_data_byte inside {[CH_ZERO:CH_NINE]});
  assign line_ok  = (in_data_byte == CH_CR) && seen_r;
  assign acc_wide = {4'b0000, acc_r};
  assign prod     = (acc_wide << 3) + (acc_wide << 1)
                    + {{LEN_WIDTH{1'b0}}, in_data_byte[3:0]};
  assign ovf      = |prod[LEN_WIDTH+3:LEN_WIDTH];

  always_comb begin
    phase_nxt  = phase_r;
    dcount_nxt = dcount_r;
    acc_nxt    = acc_r;
    seen_nxt   = seen_r;
    remain_nxt = remain_r;
    skip_nxt   = skip_r;
    tcount_nxt = tcount_r;
    excess_nxt = excess_r;
    tok_vld    = 1'b0;
    tok_res    = '0;
    verd_code  = VERD_DISCARD;

    case (phase_r)
      PH_STAR, PH_DOLLAR: begin
        if (in_data_byte == ((phase_r == PH_STAR) ? CH_STAR : CH_DOLLAR)) begin
          phase_nxt = (phase_r == PH_STAR) ? PH_CNT_DIG : PH_LEN_DIG;
          acc_nxt   = '0;
          seen_nxt  = 1'b0;
        end else begin
          phase_nxt = PH_STOP;
        end
      end
      PH_CNT_DIG, PH_LEN_DIG: begin
        if (is_digit) begin
          if (ovf) begin
            phase_nxt = PH_FAIL;
          end else begin
            acc_nxt  = prod[LEN_WIDTH-1:0];
            seen_nxt = 1'b1;
          end
        end else if (line_ok) begin
          if (phase_r == PH_CNT_DIG) begin
            dcount_nxt = acc_r;
            phase_nxt  = PH_CNT_LF;
          end else begin
            phase_nxt  = PH_LEN_LF;
          end
        end else begin
          phase_nxt = PH_FAIL;
        end
      end
      PH_CNT_LF: begin
        phase_nxt = (in_data_byte == CH_LF) ? PH_DOLLAR : PH_FAIL;
      end
      PH_LEN_LF: begin
        if (in_data_byte != CH_LF) begin
          phase_nxt = PH_FAIL;
        end else if (acc_r == '0) begin
          // zero-length element: one empty token
          tok_vld           = 1'b1;
          tok_res.kind      = KIND_EMPTY;
          tok_res.token_end = 1'b1;
          if (tcount_r == dcount_r) excess_nxt = 1'b1;
          else tcount_nxt = tcount_r + 1'b1;
          skip_nxt  = 2'd2;
          phase_nxt = PH_SKIP;
        end else begin
          remain_nxt = acc_r;
          phase_nxt  = PH_DATA;
        end
      end
      PH_DATA: begin
        remain_nxt         = remain_r - 1'b1;
        tok_vld            = 1'b1;
        tok_res.kind       = KIND_BYTE;
        tok_res.token_byte = in_data_byte;
        tok_res.token_end  = (remain_r == LEN_WIDTH'(1));
        if (remain_r == LEN_WIDTH'(1)) begin
          if (tcount_r == dcount_r) excess_nxt = 1'b1;
          else tcount_nxt = tcount_r + 1'b1;
          skip_nxt  = 2'd2;
          phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_r - 1'b1;
        if (skip_r == 2'd1) phase_nxt = PH_DOLLAR;
      end
      PH_STOP, PH_FAIL: begin
      end
      default: begin
        phase_nxt = PH_FAIL;
      end
    endcase

    // verdict from the state this byte leaves behind
    if (phase_nxt == PH_STOP) begin
      verd_code = VERD_STOPPED;
    end else if (phase_nxt == PH_DOLLAR && !excess_nxt && tcount_nxt == dcount_nxt) begin
      verd_code = VERD_ACCEPT;
    end
    tok_res.run_last = ~in_end_of_message;

    // end of message: back to reset values
    if (in_end_of_message) begin
      phase_nxt  = PH_STAR;
      dcount_nxt = '0;
      acc_nxt    = '0;
      seen_nxt   = 1'b0;
      remain_nxt = '0;
      skip_nxt   = '0;
      tcount_nxt = '0;
      excess_nxt = 1'b0;
    end
  end

  always_comb begin
    verd_res          = '0;
    verd_res.kind     = KIND_VERDICT;
    verd_res.verdict  = verd_code;
    verd_res.run_last = 1'b1;
  end

  // verdict goes behind the token when both are produced
  assign verd_addr = wr_ptr_r + QAW'(tok_vld);

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire) cnt_nxt = cnt_nxt + QCW'(tok_vld) + QCW'(in_end_of_message);
    if (out_fire) cnt_nxt = cnt_nxt - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_STAR;
      dcount_r <= '0;
      acc_r    <= '0;
      seen_r   <= 1'b0;
      remain_r <= '0;
      skip_r   <= '0;
      tcount_r <= '0;
      excess_r <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_fire) begin
        phase_r  <= phase_nxt;
        dcount_r <= dcount_nxt;
        acc_r    <= acc_nxt;
        seen_r   <= seen_nxt;
        remain_r <= remain_nxt;
        skip_r   <= skip_nxt;
        tcount_r <= tcount_nxt;
        excess_r <= excess_nxt;
        wr_ptr_r <= wr_ptr_r + QAW'(tok_vld) + QAW'(in_end_of_message);
      end
      if (out_fire) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && tok_vld) q_mem[wr_ptr_r] <= tok_res;
    if (in_fire && in_end_of_message) q_mem[verd_addr] <= verd_res;
  end

  // head of queue drives the result ports
  assign out_valid      = (cnt_r != '0);
  assign out_kind       = q_mem[rd_ptr_r].kind;
  assign out_token_byte = q_mem[rd_ptr_r].token_byte;
  assign out_token_end  = q_mem[rd_ptr_r].token_end;
  assign out_verdict    = q_mem[rd_ptr_r].verdict;
  assign out_run_last   = q_mem[rd_ptr_r].run_last;

  // checks
  `RT_ASSERT_IMP(a_queue_bound, clk, rst_n, 1'b1, cnt_r <= QCW'(QDEPTH))
  `RT_ASSERT_NXT(a_eom_resets, clk, rst_n, in_fire && in_end_of_message,
                 phase_r == PH_STAR && tcount_r == '0 && !excess_r)
  `RT_ASSERT_IMP(a_verdict_last, clk, rst_n, out_valid && out_kind == KIND_VERDICT,
                 out_run_last)
  `RT_ASSERT_IMP(a_data_left, clk, rst_n, phase_r == PH_DATA, remain_r != '0)
  `RT_ASSERT_IMP(a_tokens_bounded, clk, rst_n, 1'b1, tcount_r <= dcount_r)

endmodule

`default_nettype wire
